@@ src/lbbt_pkg.sv @@
`default_nettype none

package lbbt_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int LABEL_W       = 10;
    localparam int POS_W         = 12;
    localparam int SIZE_W        = 13;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 1;
    localparam int S_TDATA_W     = 16;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 56;
    localparam int M_TUSER_W     = 1;

    // Frame size after reset
    localparam int FRAME_W_RESET = 640;
    localparam int FRAME_H_RESET = 480;

    // Labels per word of the valid-mark memory
    localparam int VALID_ROW_W   = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Request kind on the input tuser
    localparam logic REQ_QUERY = 1'b1;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_UPDATE,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic frame_start;
        logic out_of_range;
    } t_item_ctrl;

endpackage

`default_nettype wire

@@ src/lbbt_ram.sv @@
`default_nettype none

module lbbt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]                     i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [DATA_W-1:0]                     o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/lbbt_queue.sv @@
`default_nettype none

module lbbt_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_data,
    output logic                   o_full,
    output logic                   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]     r_count,  n_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ src/lbbt_front.sv @@
`default_nettype none

module lbbt_front #(
    parameter int MAX_LABELS = 1024,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [lbbt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [lbbt_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_req_type,
    input  wire logic [lbbt_pkg::LABEL_W-1:0]         i_label,
    input  wire logic                                 i_frame_start,
    input  wire logic                                 i_q_full,
    output logic                                      o_push,
    output lbbt_pkg::t_item_ctrl                      o_ctrl,
    output logic      [lbbt_pkg::LABEL_W-1:0]         o_label,
    output logic      [$clog2(MAX_DIM)-1:0]           o_col,
    output logic      [$clog2(MAX_DIM)-1:0]           o_row
);

    import lbbt_pkg::*;

    localparam int CW    = $clog2(MAX_DIM);
    localparam int DW    = CW + 1;
    localparam int WW    = (DW > CFG_W) ? DW : CFG_W;
    localparam int W_RST = (FRAME_W_RESET > MAX_DIM) ? MAX_DIM : FRAME_W_RESET;
    localparam int H_RST = (FRAME_H_RESET > MAX_DIM) ? MAX_DIM : FRAME_H_RESET;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [WW-1:0] ext;
        ext = WW'(v);
        if (ext == '0) begin
            return DW'(1);
        end else if (ext > WW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(ext);
        end
    endfunction

    logic [DW-1:0] r_width, r_height;
    logic [CW-1:0] r_col, n_col;
    logic [DW-1:0] r_row, n_row;

    logic          accept;
    logic          is_query;
    logic          in_range;
    logic          pix_live;
    logic [CW-1:0] col_cur;
    logic [DW-1:0] row_cur;
    logic [DW-1:0] col_inc;

    // Hold the clamped frame size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DW'(W_RST);
            r_height <= DW'(H_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= clamp_dim(i_cfg_wdata);
                REG_FRAME_HEIGHT: r_height <= clamp_dim(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Classify the beat against the raster position
    always_comb begin
        is_query = (i_req_type == REQ_QUERY);
        in_range = (32'(i_label) < MAX_LABELS);
        col_cur  = i_frame_start ? '0 : r_col;
        row_cur  = i_frame_start ? '0 : r_row;
        pix_live = !is_query && (row_cur < r_height);
        col_inc  = DW'(col_cur) + DW'(1);

        o_ctrl.frame_start  = i_frame_start;
        o_ctrl.out_of_range = !in_range;
        if (is_query) begin
            o_ctrl.op = OP_QUERY;
        end else if (pix_live && in_range) begin
            o_ctrl.op = OP_UPDATE;
        end else begin
            o_ctrl.op = OP_CLEAR;
        end

        // Drop pixels that neither update a box nor start a frame
        o_push  = accept && (is_query || (pix_live && in_range) || i_frame_start);
        o_label = i_label;
        o_col   = col_cur;
        o_row   = row_cur[CW-1:0];
    end

    // Advance the raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (pix_live) begin
                if (col_inc >= r_width) begin
                    n_col = '0;
                    n_row = row_cur + DW'(1);
                end else begin
                    n_col = col_inc[CW-1:0];
                    n_row = row_cur;
                end
            end else begin
                n_col = col_cur;
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

@@ src/lbbt_back.sv @@
`default_nettype none

module lbbt_back #(
    parameter int MAX_LABELS = 1024,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    output logic                                   o_pop,
    input  wire lbbt_pkg::t_item_ctrl              i_ctrl,
    input  wire logic [lbbt_pkg::LABEL_W-1:0]      i_label,
    input  wire logic [$clog2(MAX_DIM)-1:0]        i_col,
    input  wire logic [$clog2(MAX_DIM)-1:0]        i_row,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic                                   o_found,
    output logic      [lbbt_pkg::POS_W-1:0]        o_box_x,
    output logic      [lbbt_pkg::POS_W-1:0]        o_box_y,
    output logic      [lbbt_pkg::SIZE_W-1:0]       o_box_width,
    output logic      [lbbt_pkg::SIZE_W-1:0]       o_box_height
);

    import lbbt_pkg::*;

    localparam int CW    = $clog2(MAX_DIM);
    localparam int BW    = 4 * CW;
    localparam int DEPTH = (MAX_LABELS < (1 << LABEL_W)) ? MAX_LABELS : (1 << LABEL_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = (DEPTH < VALID_ROW_W) ? DEPTH : VALID_ROW_W;
    localparam int VBW   = $clog2(VW);
    localparam int VROWS = (DEPTH + VW - 1) / VW;
    localparam int VRW   = (VROWS > 1) ? $clog2(VROWS) : 1;

    logic             adv;
    logic             do_upd;

    // Second stage: RAM data arrives, box is merged and written back
    logic             r_s1_valid;
    t_item_ctrl       r_s1_ctrl;
    logic [LABEL_W-1:0] r_s1_label;
    logic [CW-1:0]    r_s1_col, r_s1_row;

    logic [AW-1:0]    s1_addr;
    logic [VRW-1:0]   s1_vrow;
    logic [VBW-1:0]   s1_bit;

    logic [BW-1:0]    b_q, b_raw, b_wdata;
    logic [VW-1:0]    v_q, v_raw, v_word, v_wdata;
    logic             hit;

    logic [CW-1:0]    cur_min_col, cur_max_col, cur_min_row, cur_max_row;
    logic [CW-1:0]    new_min_col, new_max_col, new_min_row, new_max_row;

    // Last write to each memory, for a read that raced it
    logic [AW-1:0]    r_fwd_baddr;
    logic [BW-1:0]    r_fwd_bdata;
    logic [VRW-1:0]   r_fwd_vaddr;
    logic [VW-1:0]    r_fwd_vdata;

    // One flag per valid-mark word; a clear flag means the word reads as zero
    logic [VROWS-1:0] r_rowflag, n_rowflag;

    logic             r_out_valid;

    assign adv   = !r_out_valid || i_tready;
    assign o_pop = adv && i_q_valid;

    lbbt_ram #(
        .DATA_W (BW),
        .DEPTH  (DEPTH)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (do_upd),
        .i_waddr (s1_addr),
        .i_wdata (b_wdata),
        .i_re    (adv),
        .i_raddr (i_label[AW-1:0]),
        .o_rdata (b_q)
    );

    lbbt_ram #(
        .DATA_W (VW),
        .DEPTH  (VROWS)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (do_upd),
        .i_waddr (s1_vrow),
        .i_wdata (v_wdata),
        .i_re    (adv),
        .i_raddr (VRW'(i_label >> VBW)),
        .o_rdata (v_q)
    );

    // Advance the head of the queue into the second stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ctrl  <= i_ctrl;
            r_s1_label <= i_label;
            r_s1_col   <= i_col;
            r_s1_row   <= i_row;
        end
    end

    // Merge the stored box with the new position
    always_comb begin
        s1_addr = r_s1_label[AW-1:0];
        s1_vrow = VRW'(r_s1_label >> VBW);
        s1_bit  = r_s1_label[VBW-1:0];

        v_raw  = (r_fwd_vaddr == s1_vrow) ? r_fwd_vdata : v_q;
        v_word = (r_rowflag[s1_vrow] && !r_s1_ctrl.frame_start) ? v_raw : '0;
        hit    = v_word[s1_bit] && !r_s1_ctrl.out_of_range;

        b_raw       = (r_fwd_baddr == s1_addr) ? r_fwd_bdata : b_q;
        cur_min_col = b_raw[CW-1:0];
        cur_max_col = b_raw[2*CW-1:CW];
        cur_min_row = b_raw[3*CW-1:2*CW];
        cur_max_row = b_raw[4*CW-1:3*CW];

        if (hit) begin
            new_min_col = (r_s1_col < cur_min_col) ? r_s1_col : cur_min_col;
            new_max_col = (r_s1_col > cur_max_col) ? r_s1_col : cur_max_col;
            new_min_row = (r_s1_row < cur_min_row) ? r_s1_row : cur_min_row;
            new_max_row = (r_s1_row > cur_max_row) ? r_s1_row : cur_max_row;
        end else begin
            new_min_col = r_s1_col;
            new_max_col = r_s1_col;
            new_min_row = r_s1_row;
            new_max_row = r_s1_row;
        end

        b_wdata = {new_max_row, new_min_row, new_max_col, new_min_col};
        v_wdata = v_word | (VW'(1) << s1_bit);
        do_upd  = adv && r_s1_valid && (r_s1_ctrl.op == OP_UPDATE);
    end

    // Clear the word flags on a frame start, set the one just written
    always_comb begin
        n_rowflag = r_rowflag;
        if (adv && r_s1_valid) begin
            if (r_s1_ctrl.frame_start) begin
                n_rowflag = '0;
            end
            if (r_s1_ctrl.op == OP_UPDATE) begin
                n_rowflag[s1_vrow] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rowflag <= '0;
        end else begin
            r_rowflag <= n_rowflag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_upd) begin
            r_fwd_baddr <= s1_addr;
            r_fwd_bdata <= b_wdata;
            r_fwd_vaddr <= s1_vrow;
            r_fwd_vdata <= v_wdata;
        end
    end

    // Output register: load a query answer, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid && (r_s1_ctrl.op == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid && (r_s1_ctrl.op == OP_QUERY)) begin
            o_found <= hit;
            if (hit) begin
                o_box_x      <= POS_W'(cur_min_col);
                o_box_y      <= POS_W'(cur_min_row);
                o_box_width  <= SIZE_W'(({1'b0, cur_max_col} - {1'b0, cur_min_col})
                                        + (CW + 1)'(1));
                o_box_height <= SIZE_W'(({1'b0, cur_max_row} - {1'b0, cur_min_row})
                                        + (CW + 1)'(1));
            end else begin
                o_box_x      <= '0;
                o_box_y      <= '0;
                o_box_width  <= '0;
                o_box_height <= '0;
            end
        end
    end

    assign o_tvalid = r_out_valid;

endmodule

`default_nettype wire

@@ src/label_bounding_box_tracker.sv @@
`default_nettype none

// Per-label bounding box tracker.
// Input stream (s_axis): one beat per raster pixel or per box query.
//   tuser[0] = 1 asks for the box of the label in tdata, 0 carries a pixel;
//   tuser[1] marks the first beat of a frame and clears every box and the
//   raster position before the beat itself is handled.
// Output stream (m_axis): one beat per query; tuser[0] is the found flag and
//   tdata carries x, y, width and height (all zero when not found).
// Configuration: i_cfg_we with i_cfg_idx 0 sets the frame width, 1 the frame
//   height; values clamp to 1..MAX_DIM and should change only while idle.
// Throughput is one beat per cycle on both sides while m_axis is ready. A query
//   answer passes from the four-entry queue between the front end and the back
//   end through the box memory read stage into the output register, which
//   presents it.
// When m_axis stalls, the back end holds, the four-entry queue fills and
//   s_axis_tready drops until the answer is taken; nothing is lost.
// Reset (i_rst_n low, synchronous) clears all boxes, the position and the
//   queue, and restores a 640 x 480 frame; no clearing pass is needed.
module label_bounding_box_tracker #(
    parameter int MAX_LABELS = 1024,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lbbt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lbbt_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lbbt_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // pixel_label
    input  wire logic [lbbt_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // req_type, frame_start
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [lbbt_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // box_x, box_y,
                                                                   // box_width, box_height
    output logic      [lbbt_pkg::M_TUSER_W-1:0]     m_axis_tuser   // found
);

    import lbbt_pkg::*;

    localparam int CW      = $clog2(MAX_DIM);
    localparam int CTRL_W  = $bits(t_item_ctrl);
    localparam int Q_W     = CTRL_W + LABEL_W + 2 * CW;
    localparam int Q_DEPTH = 4;
    localparam int PAD_W   = M_TDATA_W - 2 * POS_W - 2 * SIZE_W;

    t_item_ctrl       f_ctrl, b_ctrl;
    logic [LABEL_W-1:0] f_label;
    logic [CW-1:0]    f_col, f_row;
    logic             f_push;
    logic             q_full, q_empty, q_pop;
    logic [Q_W-1:0]   q_out;

    logic             found;
    logic [POS_W-1:0] box_x, box_y;
    logic [SIZE_W-1:0] box_width, box_height;

    lbbt_front #(
        .MAX_LABELS (MAX_LABELS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser[0]),
        .i_label       (s_axis_tdata[LABEL_W-1:0]),
        .i_frame_start (s_axis_tuser[1]),
        .i_q_full      (q_full),
        .o_push        (f_push),
        .o_ctrl        (f_ctrl),
        .o_label       (f_label),
        .o_col         (f_col),
        .o_row         (f_row)
    );

    lbbt_queue #(
        .DATA_W (Q_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctrl, f_label, f_col, f_row}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_ctrl = t_item_ctrl'(q_out[Q_W-1 -: CTRL_W]);

    lbbt_back #(
        .MAX_LABELS (MAX_LABELS),
        .MAX_DIM    (MAX_DIM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (!q_empty),
        .o_pop        (q_pop),
        .i_ctrl       (b_ctrl),
        .i_label      (q_out[2*CW +: LABEL_W]),
        .i_col        (q_out[CW +: CW]),
        .i_row        (q_out[CW-1:0]),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_found      (found),
        .o_box_x      (box_x),
        .o_box_y      (box_y),
        .o_box_width  (box_width),
        .o_box_height (box_height)
    );

    // Pack the answer, lowest field first
    assign m_axis_tdata = {{PAD_W{1'b0}}, box_height, box_width, box_y, box_x};
    assign m_axis_tuser = M_TUSER_W'(found);

endmodule

`default_nettype wire
